// ----- design/pgpm_pkg.sv -----
// Package for the pixel to ground plane mapper: item, configuration and
// divider-lane types, status and register codes, and the 24-bit saturation.
// No dependencies.
`default_nettype none
package pgpm_pkg;

  localparam int DEN_W = 32;   // positive denominator magnitude
  localparam int REM_W = 64;   // numerator magnitude plus rounding half
  localparam int Q_W = 26;     // quotient bits kept; the top one means saturated
  localparam int CMP_W = 72;   // room for the denominator at the largest shift
  localparam int DIV_SHIFT = 14;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_OUT = 2'd1;
  localparam logic [1:0] ST_IN = 2'd2;

  localparam logic [2:0] REG_SINE_TILT = 3'd0;
  localparam logic [2:0] REG_COSINE_TILT = 3'd1;
  localparam logic [2:0] REG_SINE_PAN = 3'd2;
  localparam logic [2:0] REG_COSINE_PAN = 3'd3;
  localparam logic [2:0] REG_FOCAL = 3'd4;
  localparam logic [2:0] REG_MOUNT = 3'd5;
  localparam logic [2:0] REG_OFFSET = 3'd6;
  localparam logic [2:0] REG_M2P = 3'd7;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] target_height;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic signed [23:0] ground_u;
    logic signed [23:0] ground_v;
  } out_t;

  typedef struct packed {
    logic signed [15:0] sine_tilt;
    logic signed [15:0] cosine_tilt;
    logic signed [15:0] sine_pan;
    logic signed [15:0] cosine_pan;
    logic [12:0] focal_pixels;
    logic [15:0] mount_height;
    logic [22:0] ground_offset;
    logic [15:0] meters_to_pixels;
  } cfg_t;

  // One item as it travels down the divider chain; lanes are x, y, z.
  typedef struct packed {
    logic inv;
    logic [DEN_W-1:0] den;
    logic [2:0] neg;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][Q_W-1:0] quo;
  } div_t;

  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    logic signed [23:0] r;
    if (v > 34'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (v < -34'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/pgpm_front.sv -----
// Front end of the mapper: denominator, height difference, rotation products
// and signed numerators over three stages. Depends on pgpm_pkg.
`default_nettype none
module pgpm_front #(
  parameter int CAM_WIDTH = 1024,
  parameter int CAM_HEIGHT = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 vld_i,
  input  pgpm_pkg::in_t       item_i,
  input  pgpm_pkg::cfg_t      cfg_i,
  output logic                vld_o,
  output pgpm_pkg::div_t      div_o
);

  localparam logic signed [13:0] CamW = 14'(CAM_WIDTH);
  localparam logic signed [13:0] CamH = 14'(CAM_HEIGHT);

  // stage 0 combinational
  logic signed [13:0] dx, dy;
  logic signed [15:0] fz;
  logic signed [32:0] den_s;
  logic signed [16:0] dh;
  logic inv0;

  always_comb begin
    dx = $signed({1'b0, item_i.pixel_x, 1'b0}) - CamW;
    dy = $signed({1'b0, item_i.pixel_y, 1'b0}) - CamH;
    fz = $signed({2'b00, cfg_i.focal_pixels, 1'b0});
    den_s = 33'(fz * cfg_i.sine_tilt) + 33'(dy * cfg_i.cosine_tilt);
    dh = $signed({1'b0, cfg_i.mount_height}) - $signed({1'b0, item_i.target_height});
    inv0 = (den_s <= 33'sd0) || (item_i.target_height > cfg_i.mount_height);
  end

  // stage 1
  logic v1_q, inv1_q;
  logic [31:0] den1_q;
  logic signed [30:0] dhdx_q, dhdy_q;
  logic signed [32:0] dhfz_q;
  logic signed [31:0] sst_q, sct_q, cst_q, cct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    inv1_q <= inv0;
    den1_q <= den_s[31:0];
    dhdx_q <= 31'(dh * dx);
    dhdy_q <= 31'(dh * dy);
    dhfz_q <= 33'(dh * fz);
    sst_q <= 32'(cfg_i.sine_pan * cfg_i.sine_tilt);
    sct_q <= 32'(cfg_i.sine_pan * cfg_i.cosine_tilt);
    cst_q <= 32'(cfg_i.cosine_pan * cfg_i.sine_tilt);
    cct_q <= 32'(cfg_i.cosine_pan * cfg_i.cosine_tilt);
  end

  // stage 2: one multiplier per product
  logic v2_q, inv2_q;
  logic [31:0] den2_q;
  logic signed [46:0] xa_q, ya_q, za_q;
  logic signed [62:0] xb_q, zb_q;
  logic signed [64:0] xc_q, zc_q;
  logic signed [48:0] yb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inv2_q <= inv1_q;
    den2_q <= den1_q;
    xa_q <= 47'(cfg_i.cosine_pan * dhdx_q);
    xb_q <= 63'(sst_q * dhdy_q);
    xc_q <= 65'(sct_q * dhfz_q);
    ya_q <= 47'(cfg_i.cosine_tilt * dhdy_q);
    yb_q <= 49'(cfg_i.sine_tilt * dhfz_q);
    za_q <= 47'(cfg_i.sine_pan * dhdx_q);
    zb_q <= 63'(cst_q * dhdy_q);
    zc_q <= 65'(cct_q * dhfz_q);
  end

  // stage 2 to 3: signed numerators, then magnitude plus half the divisor
  logic signed [63:0] ax, ay, az;
  pgpm_pkg::div_t div_d;

  always_comb begin
    ax = (64'(xa_q) <<< 14) - 64'(xb_q) + 64'(xc_q);
    ay = (64'(ya_q) + 64'(yb_q)) <<< 14;
    az = 64'(zc_q) - 64'(zb_q) - (64'(za_q) <<< 14);
    div_d.inv = inv2_q;
    div_d.den = den2_q;
    div_d.neg = {az[63], ay[63], ax[63]};
    div_d.rem[0] = (ax[63] ? 64'(-ax) : 64'(ax)) + {19'd0, den2_q, 13'd0};
    div_d.rem[1] = (ay[63] ? 64'(-ay) : 64'(ay)) + {19'd0, den2_q, 13'd0};
    div_d.rem[2] = (az[63] ? 64'(-az) : 64'(az)) + {19'd0, den2_q, 13'd0};
    div_d.quo = '0;
  end

  logic v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_o <= div_d;
  end

  assign vld_o = v3_q;

endmodule
`default_nettype wire

// ----- design/pgpm_div_cell.sv -----
// One cell of the divider chain: decides one quotient bit on all three lanes
// by a trial subtraction of the shifted divisor. Depends on pgpm_pkg.
`default_nettype none
module pgpm_div_cell #(
  parameter int BIT = 0
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             vld_i,
  input  pgpm_pkg::div_t  div_i,
  output logic            vld_o,
  output pgpm_pkg::div_t  div_o
);

  localparam int Shift = pgpm_pkg::DIV_SHIFT + BIT;

  logic [pgpm_pkg::CMP_W-1:0] divisor;
  logic [pgpm_pkg::CMP_W-1:0] trial [3];
  pgpm_pkg::div_t div_d;
  logic vld_q;

  always_comb begin
    divisor = pgpm_pkg::CMP_W'(div_i.den) << Shift;
    div_d = div_i;
    for (int l = 0; l < 3; l++) begin
      trial[l] = pgpm_pkg::CMP_W'(div_i.rem[l]) - divisor;
      if (pgpm_pkg::CMP_W'(div_i.rem[l]) >= divisor) begin
        div_d.rem[l] = trial[l][pgpm_pkg::REM_W-1:0];
        div_d.quo[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_o <= div_d;
  end

  assign vld_o = vld_q;

endmodule
`default_nettype wire

// ----- design/pgpm_back.sv -----
// Back end of the mapper: signs the quotients, offsets world x, saturates, scales
// to ground-image pixels and sets the status. Depends on pgpm_pkg.
`default_nettype none
module pgpm_back #(
  parameter int GROUND_COLS = 4096,
  parameter int GROUND_ROWS = 4096
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             vld_i,
  input  pgpm_pkg::div_t  div_i,
  input  pgpm_pkg::cfg_t  cfg_i,
  output logic            done_o,
  output pgpm_pkg::out_t  result_o
);

  localparam logic signed [33:0] ColLim = 34'(GROUND_COLS) <<< 8;
  localparam logic signed [33:0] RowLim = 34'(GROUND_ROWS) <<< 8;

  // Rounded division by 256, ties away from zero.
  function automatic logic signed [33:0] rnd256(input logic signed [40:0] p);
    logic [40:0] mag;
    logic [32:0] q;
    mag = p[40] ? 41'(-p) : 41'(p);
    q = 33'((mag + 41'd128) >> 8);
    return p[40] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // stage 1: signed world values
  logic signed [27:0] qx, qy, qz;
  logic b1_q, inv1_q;
  logic signed [23:0] wx_q, wy_q, wz_q;

  always_comb begin
    qx = div_i.neg[0] ? -$signed({2'b00, div_i.quo[0]}) : $signed({2'b00, div_i.quo[0]});
    qy = div_i.neg[1] ? -$signed({2'b00, div_i.quo[1]}) : $signed({2'b00, div_i.quo[1]});
    qz = div_i.neg[2] ? -$signed({2'b00, div_i.quo[2]}) : $signed({2'b00, div_i.quo[2]});
  end

  always_ff @(posedge clk_i) begin
    inv1_q <= div_i.inv;
    wx_q <= pgpm_pkg::sat24(34'(qx) + 34'($signed({1'b0, cfg_i.ground_offset})));
    wy_q <= pgpm_pkg::sat24(34'(qy));
    wz_q <= pgpm_pkg::sat24(34'(qz));
  end

  // stage 2: scale products
  logic b2_q, inv2_q;
  logic signed [23:0] wx2_q, wy2_q, wz2_q;
  logic signed [40:0] pu_q, pv_q;

  always_ff @(posedge clk_i) begin
    inv2_q <= inv1_q;
    wx2_q <= wx_q;
    wy2_q <= wy_q;
    wz2_q <= wz_q;
    pu_q <= 41'(wz_q * $signed({1'b0, cfg_i.meters_to_pixels}));
    pv_q <= 41'(wx_q * $signed({1'b0, cfg_i.meters_to_pixels}));
  end

  // stage 3: rounding, bounds and output register
  logic signed [33:0] u, v;
  pgpm_pkg::out_t res_d;
  logic done_q;

  always_comb begin
    u = rnd256(pu_q);
    v = rnd256(pv_q);
    res_d = '0;
    if (!inv2_q) begin
      res_d.status = (u >= 34'sd0 && u < ColLim && v >= 34'sd0 && v < RowLim)
                     ? pgpm_pkg::ST_IN : pgpm_pkg::ST_OUT;
      res_d.world_x = wx2_q;
      res_d.world_y = wy2_q;
      res_d.world_z = wz2_q;
      res_d.ground_u = pgpm_pkg::sat24(u);
      res_d.ground_v = pgpm_pkg::sat24(v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q <= 1'b0;
      b2_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      b1_q <= vld_i;
      b2_q <= b1_q;
      done_q <= b2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    result_o <= res_d;
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

// ----- design/pixel_to_ground_plane_mapper_core.sv -----
// Pixel to ground plane mapper, top level: registers, front end, divider chain
// of 26 cells and back end. Depends on pgpm_pkg and the pgpm_* modules.
// A result reaches done_o through the front end, the divider cells and the back end.
// Throughput: one item per cycle; busy_o stays low, the pipeline never stalls
// and the receiver cannot hold results off. The depth is set by the chain of
// one-bit divider cells. Reset empties the pipeline and loads register defaults.
`default_nettype none
module pixel_to_ground_plane_mapper_core #(
  parameter int CAM_WIDTH = 1024,
  parameter int CAM_HEIGHT = 1024,
  parameter int GROUND_COLS = 4096,
  parameter int GROUND_ROWS = 4096
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  output logic            busy_o,
  input  pgpm_pkg::in_t   item_i,
  output logic            done_o,
  output pgpm_pkg::out_t  result_o,
  input  wire             cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire [2:0]       cfg_index_i,
  input  wire [22:0]      cfg_data_i
);

  localparam int Lat = 32;

  pgpm_pkg::cfg_t cfg_q;

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sine_tilt <= 16'sd0;
      cfg_q.cosine_tilt <= 16'sd16384;
      cfg_q.sine_pan <= 16'sd0;
      cfg_q.cosine_pan <= 16'sd16384;
      cfg_q.focal_pixels <= 13'd1000;
      cfg_q.mount_height <= 16'd2560;
      cfg_q.ground_offset <= 23'd0;
      cfg_q.meters_to_pixels <= 16'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pgpm_pkg::REG_SINE_TILT: cfg_q.sine_tilt <= cfg_data_i[15:0];
        pgpm_pkg::REG_COSINE_TILT: cfg_q.cosine_tilt <= cfg_data_i[15:0];
        pgpm_pkg::REG_SINE_PAN: cfg_q.sine_pan <= cfg_data_i[15:0];
        pgpm_pkg::REG_COSINE_PAN: cfg_q.cosine_pan <= cfg_data_i[15:0];
        pgpm_pkg::REG_FOCAL: cfg_q.focal_pixels <= cfg_data_i[12:0];
        pgpm_pkg::REG_MOUNT: cfg_q.mount_height <= cfg_data_i[15:0];
        pgpm_pkg::REG_OFFSET: cfg_q.ground_offset <= cfg_data_i;
        pgpm_pkg::REG_M2P: cfg_q.meters_to_pixels <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start_i && !busy_o;

  logic [pgpm_pkg::Q_W:0] chain_vld;
  pgpm_pkg::div_t chain [pgpm_pkg::Q_W+1];

  pgpm_front #(
    .CAM_WIDTH(CAM_WIDTH),
    .CAM_HEIGHT(CAM_HEIGHT)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .vld_i(accept),
    .item_i(item_i),
    .cfg_i(cfg_q),
    .vld_o(chain_vld[0]),
    .div_o(chain[0])
  );

  // Cell k decides quotient bit Q_W-1-k, most significant first.
  for (genvar k = 0; k < pgpm_pkg::Q_W; k++) begin : g_cell
    pgpm_div_cell #(
      .BIT(pgpm_pkg::Q_W - 1 - k)
    ) u_cell (
      .clk_i(clk_i),
      .rst_ni(rst_ni),
      .vld_i(chain_vld[k]),
      .div_i(chain[k]),
      .vld_o(chain_vld[k+1]),
      .div_o(chain[k+1])
    );
  end

  pgpm_back #(
    .GROUND_COLS(GROUND_COLS),
    .GROUND_ROWS(GROUND_ROWS)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .vld_i(chain_vld[pgpm_pkg::Q_W]),
    .div_i(chain[pgpm_pkg::Q_W]),
    .cfg_i(cfg_q),
    .done_o(done_o),
    .result_o(result_o)
  );

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Lat))
    else $error("result without a matching item");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == pgpm_pkg::ST_NONE |->
      result_o.world_x == '0 && result_o.world_y == '0 && result_o.world_z == '0 &&
      result_o.ground_u == '0 && result_o.ground_v == '0)
    else $error("no-hit result carries nonzero fields");

  a_inside_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == pgpm_pkg::ST_IN |->
      !result_o.ground_u[23] && !result_o.ground_v[23])
    else $error("inside status with negative ground coordinate");

endmodule
`default_nettype wire

// ----- tb/tb_pixel_to_ground_plane_mapper_core.sv -----
// Testbench for pixel_to_ground_plane_mapper_core: drives camera pixels and register
// writes, predicts every ground-plane result in exact arithmetic and checks them in order.
// Depends on pgpm_pkg and the mapper RTL.
`default_nettype none
module tb_pixel_to_ground_plane_mapper_core;

  localparam int LATENCY = 32;
  localparam longint CYCLE_LIMIT = 400000;

  // Register shadow and expected-result queue with the ground-plane arithmetic.
  class mapping_scoreboard;
    longint s_tilt, c_tilt, s_pan, c_pan, focal, mount, offset, m2p;
    pgpm_pkg::out_t pending[$];
    int mismatches;

    function void load_defaults();
      s_tilt = 0; c_tilt = 16384; s_pan = 0; c_pan = 16384;
      focal = 1000; mount = 2560; offset = 0; m2p = 256;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [22:0] data);
      case (idx)
        pgpm_pkg::REG_SINE_TILT: s_tilt = longint'($signed(data[15:0]));
        pgpm_pkg::REG_COSINE_TILT: c_tilt = longint'($signed(data[15:0]));
        pgpm_pkg::REG_SINE_PAN: s_pan = longint'($signed(data[15:0]));
        pgpm_pkg::REG_COSINE_PAN: c_pan = longint'($signed(data[15:0]));
        pgpm_pkg::REG_FOCAL: focal = longint'(data[12:0]);
        pgpm_pkg::REG_MOUNT: mount = longint'(data[15:0]);
        pgpm_pkg::REG_OFFSET: offset = longint'(data[22:0]);
        pgpm_pkg::REG_M2P: m2p = longint'(data[15:0]);
        default: ;
      endcase
    endfunction

    // Rounds to nearest with ties away from zero.
    function logic signed [127:0] round_div(logic signed [127:0] num, logic signed [127:0] d);
      logic signed [127:0] mag;
      logic signed [127:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag + d / 2) / d;
      return (num < 0) ? -q : q;
    endfunction

    function logic signed [127:0] clip24(logic signed [127:0] v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function void note_item(pgpm_pkg::in_t it);
      logic signed [127:0] dx, dy, fz, den, dh, ax, ay, az, dv, wx, wy, wz, u, v;
      pgpm_pkg::out_t r;
      dx = 2 * longint'(it.pixel_x) - 1024;
      dy = 2 * longint'(it.pixel_y) - 1024;
      fz = 2 * focal;
      den = fz * s_tilt + dy * c_tilt;
      r = '0;
      if (den > 0 && longint'(it.target_height) <= mount) begin
        dh = mount - longint'(it.target_height);
        ax = c_pan * 16384 * dx - s_pan * s_tilt * dy + s_pan * c_tilt * fz;
        ay = c_tilt * 16384 * dy + s_tilt * 16384 * fz;
        az = -s_pan * 16384 * dx - c_pan * s_tilt * dy + c_pan * c_tilt * fz;
        dv = den * 16384;
        wx = clip24(round_div(ax * dh, dv) + offset);
        wy = clip24(round_div(ay * dh, dv));
        wz = clip24(round_div(az * dh, dv));
        u = round_div(wz * m2p, 256);
        v = round_div(wx * m2p, 256);
        r.status = (u >= 0 && u < 4096 * 256 && v >= 0 && v < 4096 * 256)
                   ? pgpm_pkg::ST_IN : pgpm_pkg::ST_OUT;
        r.world_x = wx[23:0];
        r.world_y = wy[23:0];
        r.world_z = wz[23:0];
        u = clip24(u);
        v = clip24(v);
        r.ground_u = u[23:0];
        r.ground_v = v[23:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(pgpm_pkg::out_t got);
      pgpm_pkg::out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.world_x !== want.world_x ||
          got.world_y !== want.world_y || got.world_z !== want.world_z ||
          got.ground_u !== want.ground_u || got.ground_v !== want.ground_v) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected st=%0d x=%0d y=%0d z=%0d u=%0d v=%0d",
                   want.status, want.world_x, want.world_y, want.world_z, want.ground_u,
                   want.ground_v);
          $display("          got      st=%0d x=%0d y=%0d z=%0d u=%0d v=%0d",
                   got.status, got.world_x, got.world_y, got.world_z,
                   got.ground_u, got.ground_v);
        end
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, done, cfg_valid, cfg_ready;
  pgpm_pkg::in_t item;
  pgpm_pkg::out_t result;
  logic [2:0] cfg_index;
  logic [22:0] cfg_data;
  int idle_pct;
  longint cycles;
  mapping_scoreboard board;

  pixel_to_ground_plane_mapper_core dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .item_i(item),
    .done_o(done), .result_o(result), .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && done) board.check_result(result);
  end

  // Drops valid between writes so that valid is never driven twice at one edge.
  task automatic write_reg(logic [2:0] idx, logic [22:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(pgpm_pkg::in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(it);
  endtask

  // Waits for every expected item, then lets the pipeline run dry before a write.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic pgpm_pkg::in_t random_item();
    pgpm_pkg::in_t it;
    it.pixel_x = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(1023));
    it.pixel_y = $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(1023));
    case ($urandom_range(3))
      0: it.target_height = 16'($urandom);
      default: it.target_height = 16'($urandom_range(board.mount));
    endcase
    return it;
  endfunction

  task automatic random_config(bit extreme);
    int a;
    a = $urandom_range(15);
    if (extreme) begin
      write_reg(pgpm_pkg::REG_SINE_TILT, 23'($urandom_range(1) ? 16'sh4000 : 16'sh8000));
      write_reg(pgpm_pkg::REG_COSINE_TILT,
                23'($urandom_range(1) ? -16'sd16384 : 16'sh7FFF));
      write_reg(pgpm_pkg::REG_SINE_PAN, 23'($urandom_range(1) ? -16'sd16384 : 16'sd16384));
      write_reg(pgpm_pkg::REG_COSINE_PAN, 23'($urandom_range(1) ? 16'sd0 : 16'sh8000));
      write_reg(pgpm_pkg::REG_FOCAL, $urandom_range(1) ? 23'd8191 : 23'd0);
      write_reg(pgpm_pkg::REG_MOUNT, 23'hFFFF);
      write_reg(pgpm_pkg::REG_OFFSET, 23'h7FFFFF);
      write_reg(pgpm_pkg::REG_M2P, $urandom_range(1) ? 23'hFFFF : 23'd0);
    end else begin
      // Tilt mostly downwards so that most rays reach the ground.
      write_reg(pgpm_pkg::REG_SINE_TILT, 23'(16'($urandom_range(16384, 2000))));
      write_reg(pgpm_pkg::REG_COSINE_TILT, 23'(16'(int'($urandom_range(32768)) - 16384)));
      write_reg(pgpm_pkg::REG_SINE_PAN, 23'(16'(int'($urandom_range(32768)) - 16384)));
      write_reg(pgpm_pkg::REG_COSINE_PAN, 23'(16'(int'($urandom_range(32768)) - 16384)));
      write_reg(pgpm_pkg::REG_FOCAL, 23'($urandom_range(8191, 1)));
      write_reg(pgpm_pkg::REG_MOUNT, 23'($urandom_range(65535)));
      write_reg(pgpm_pkg::REG_OFFSET, a < 4 ? 23'($urandom) : 23'($urandom_range(262144)));
      write_reg(pgpm_pkg::REG_M2P, 23'($urandom_range(65535)));
    end
  endtask

  initial begin
    board = new();
    board.load_defaults();
    rst_n = 1'b0;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes at reset settings, then a tilted and panned camera, then a looking-up camera.
    send_item('{12'd0, 12'd0, 16'd0});
    send_item('{12'hFFF, 12'hFFF, 16'hFFFF});
    send_item('{12'd512, 12'd1023, 16'd2560});
    send_item('{12'd512, 12'd1000, 16'd2561});
    send_item('{12'd512, 12'd512, 16'd0});
    send_item('{12'd0, 12'hFFF, 16'd0});
    send_item('{12'hFFF, 12'd600, 16'd100});
    send_item('{12'hAAA, 12'h555, 16'hAAAA});
    send_item('{12'h555, 12'hAAA, 16'h5555});
    drain();
    write_reg(pgpm_pkg::REG_SINE_TILT, 23'(16'sd11585));
    write_reg(pgpm_pkg::REG_COSINE_TILT, 23'(16'sd11585));
    write_reg(pgpm_pkg::REG_SINE_PAN, 23'(16'sd8192));
    write_reg(pgpm_pkg::REG_COSINE_PAN, 23'(16'sd14189));
    write_reg(pgpm_pkg::REG_FOCAL, 23'd500);
    write_reg(pgpm_pkg::REG_MOUNT, 23'd65535);
    write_reg(pgpm_pkg::REG_OFFSET, 23'd524288);
    write_reg(pgpm_pkg::REG_M2P, 23'd65535);
    send_item('{12'd0, 12'd0, 16'd0});
    send_item('{12'd1023, 12'd1023, 16'd0});
    send_item('{12'd512, 12'd512, 16'hFFFF});
    send_item('{12'hFFF, 12'hFFF, 16'd1000});
    send_item('{12'd100, 12'd0, 16'hFFFE});
    drain();
    write_reg(pgpm_pkg::REG_SINE_TILT, 23'(-16'sd16384));
    send_item('{12'd512, 12'd512, 16'd0});
    drain();

    for (int phase = 0; phase < 24; phase++) begin
      idle_pct = phase < 8 ? 30 : (phase < 16 ? 76 : 0);
      random_config(phase % 6 == 5);
      for (int n = 0; n < 60; n++) begin
        send_item(random_item());
        if (n == 30 && phase == 3) begin
          start <= 1'b0;
          @(posedge clk);
          while (board.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    start <= 1'b0;
    repeat (LATENCY + 4) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- pixel_to_ground_plane_mapper_core.f -----
design/pgpm_pkg.sv
design/pgpm_front.sv
design/pgpm_div_cell.sv
design/pgpm_back.sv
design/pixel_to_ground_plane_mapper_core.sv
tb/tb_pixel_to_ground_plane_mapper_core.sv
